>>> hdl/lwfc_pkg.sv
// shared types, constants and helpers for the window fill command generator
`default_nettype none

package lwfc_pkg;

  localparam logic [8:0] LIMIT_MAX = 9'd256;

  localparam logic [8:0] X_LIMIT_RST = 9'd128;
  localparam logic [8:0] Y_LIMIT_RST = 9'd160;
  localparam logic [7:0] COL_OFFSET_RST = 8'd0;
  localparam logic [7:0] ROW_OFFSET_RST = 8'd0;

  // configuration register indexes
  localparam logic [1:0] REG_X_LIMIT = 2'd0;
  localparam logic [1:0] REG_Y_LIMIT = 2'd1;
  localparam logic [1:0] REG_COL_OFFSET = 2'd2;
  localparam logic [1:0] REG_ROW_OFFSET = 2'd3;

  // draw opcodes
  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_HLINE = 2'd1;
  localparam logic [1:0] OP_VLINE = 2'd2;
  localparam logic [1:0] OP_RECT = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;

  // panel command bytes
  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;
  localparam logic [7:0] FRAME_HIGH = 8'h00;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [15:0]        color;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] run_color;
    logic [16:0] run_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [8:0] x_limit;
    logic [8:0] y_limit;
    logic [7:0] column_offset;
    logic [7:0] row_offset;
  } cfg_t;

  // one request, window bytes already offset
  typedef struct packed {
    logic [7:0]  x0;
    logic [7:0]  x1;
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [15:0] color;
    logic [16:0] count;
  } job_t;

  function automatic logic [8:0] eff_limit(input logic [8:0] lim);
    eff_limit = (lim > LIMIT_MAX) ? LIMIT_MAX : lim;
  endfunction

  // clip size so that start + size stays within limit (start < limit)
  function automatic logic [8:0] clip_size(input logic [7:0] start, input logic [14:0] size,
                                           input logic [8:0] lim);
    logic [15:0] sum;
    sum = {8'd0, start} + {1'b0, size};
    if ((size != 15'd0) && (sum > {7'd0, lim})) begin
      clip_size = lim - {1'b0, start};
    end else begin
      clip_size = size[8:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/lcd_window_fill_command_generator.sv
// top level of the lcd address-window fill command generator
`default_nettype none

// channel | direction | handshake           | payload
// in_     | in        | in_push / in_full   | in_item (in_item_t)
// out_    | out       | out_pop / out_empty | out_item (out_item_t)
// cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// a kept request gives twelve beats, one per cycle while out_pop holds high;
// the back-end beat sequencer sets the pace; a job leaves the queue with its run beat
// a dropped request is taken like any other and gives no beat
// a request passes the front register, the queue and the output register before its first beat
// rst_n is synchronous; it empties the pipeline and loads the register defaults
// a stalled output holds its beat; the front takes requests until the queue and front register are full

module lcd_window_fill_command_generator import lwfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push;
  job_t q_wr_job;
  logic q_full;
  logic q_pop;
  job_t q_rd_job;
  logic q_empty;

  // the user must issue register writes only while idle; the block does not enforce this, so always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_limit       <= X_LIMIT_RST;
      cfg_r.y_limit       <= Y_LIMIT_RST;
      cfg_r.column_offset <= COL_OFFSET_RST;
      cfg_r.row_offset    <= ROW_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_X_LIMIT:    cfg_r.x_limit       <= cfg_data;
        REG_Y_LIMIT:    cfg_r.y_limit       <= cfg_data;
        REG_COL_OFFSET: cfg_r.column_offset <= cfg_data[7:0];
        REG_ROW_OFFSET: cfg_r.row_offset    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: drop check, clipping, window ends and pixel count
  lwfc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_wr_job)
  );

  // decouples front and back so either can stall alone
  lwfc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .empty  (q_empty)
  );

  // back: command, data and colour-run beats
  lwfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_rd_job),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> hdl/lwfc_front.sv
// front end: accepts requests, drops out-of-panel starts, clips and builds the job
`default_nettype none

module lwfc_front import lwfc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output job_t     q_job
);

  logic [8:0]  xl;
  logic [8:0]  yl;
  logic        drop;
  logic        accept;
  logic        take;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [1:0]  s1_op_r;
  logic [7:0]  s1_x_r;
  logic [7:0]  s1_y_r;
  logic [8:0]  s1_w_r;
  logic [8:0]  s1_h_r;
  logic [15:0] s1_color_r;

  logic [16:0] product;
  logic [7:0]  x_end;
  logic [7:0]  y_end;
  logic [16:0] count;

  assign xl = eff_limit(cfg.x_limit);
  assign yl = eff_limit(cfg.y_limit);

  assign drop = in_item.start_x[15] | in_item.start_y[15] |
                (in_item.start_x >= $signed({7'd0, xl})) |
                (in_item.start_y >= $signed({7'd0, yl}));

  assign take    = s1_valid_r & ~q_full;
  assign in_full = s1_valid_r & q_full;
  assign accept  = in_push & ~in_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b0;
    end
    if (accept && !drop) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      s1_op_r    <= in_item.opcode;
      s1_x_r     <= in_item.start_x[7:0];
      s1_y_r     <= in_item.start_y[7:0];
      s1_w_r     <= clip_size(in_item.start_x[7:0], in_item.width, xl);
      s1_h_r     <= clip_size(in_item.start_y[7:0], in_item.height, yl);
      s1_color_r <= in_item.color;
    end
  end

  // second half: window end and pixel count per opcode
  // clipped sizes are at most 256 each, so the product fits 17 bits
  assign product = {8'd0, s1_w_r} * {8'd0, s1_h_r};

  always_comb begin
    case (s1_op_r)
      OP_PIXEL: begin
        x_end = s1_x_r + 8'd1;
        y_end = s1_y_r + 8'd1;
        count = 17'd1;
      end
      OP_HLINE: begin
        x_end = s1_x_r + s1_w_r[7:0] - 8'd1;
        y_end = s1_y_r;
        count = {8'd0, s1_w_r};
      end
      OP_VLINE: begin
        x_end = s1_x_r;
        y_end = s1_y_r + s1_h_r[7:0] - 8'd1;
        count = {8'd0, s1_h_r};
      end
      default: begin
        x_end = s1_x_r + s1_w_r[7:0] - 8'd1;
        y_end = s1_y_r + s1_h_r[7:0] - 8'd1;
        count = product;
      end
    endcase
  end

  assign q_push      = take;
  assign q_job.x0    = s1_x_r + cfg.column_offset;
  assign q_job.x1    = x_end + cfg.column_offset;
  assign q_job.y0    = s1_y_r + cfg.row_offset;
  assign q_job.y1    = y_end + cfg.row_offset;
  assign q_job.color = s1_color_r;
  assign q_job.count = count;

endmodule

`default_nettype wire

>>> hdl/lwfc_queue.sv
// two-entry job queue between front and back
`default_nettype none

module lwfc_queue import lwfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output job_t rd_job,
  output logic empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill_r == 2'd2);
  assign empty   = (fill_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_job  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

>>> hdl/lwfc_back.sv
// back end: steps through the twelve beats of a job into the output register
`default_nettype none

module lwfc_back import lwfc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);

  localparam logic [3:0] STEP_COL_CMD = 4'd0;
  localparam logic [3:0] STEP_X0      = 4'd2;
  localparam logic [3:0] STEP_X1      = 4'd4;
  localparam logic [3:0] STEP_ROW_CMD = 4'd5;
  localparam logic [3:0] STEP_Y0      = 4'd7;
  localparam logic [3:0] STEP_Y1      = 4'd9;
  localparam logic [3:0] STEP_MEM_CMD = 4'd10;
  localparam logic [3:0] STEP_RUN     = 4'd11;

  logic [3:0] step_r;
  logic [3:0] step_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_r;
  out_item_t  beat;
  logic       load;

  assign load      = ~q_empty & (~out_valid_r | out_pop);
  assign q_pop     = load & (step_r == STEP_RUN);
  assign out_empty = ~out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    beat = '0;
    beat.kind = KIND_DATA;
    beat.byte_value = FRAME_HIGH;
    case (step_r)
      STEP_COL_CMD: begin
        beat.kind = KIND_CMD;
        beat.byte_value = CMD_COLUMN_SET;
      end
      STEP_X0: beat.byte_value = q_job.x0;
      STEP_X1: beat.byte_value = q_job.x1;
      STEP_ROW_CMD: begin
        beat.kind = KIND_CMD;
        beat.byte_value = CMD_ROW_SET;
      end
      STEP_Y0: beat.byte_value = q_job.y0;
      STEP_Y1: beat.byte_value = q_job.y1;
      STEP_MEM_CMD: begin
        beat.kind = KIND_CMD;
        beat.byte_value = CMD_MEM_WRITE;
      end
      STEP_RUN: begin
        beat.kind = KIND_RUN;
        beat.byte_value = 8'd0;
        beat.run_color = q_job.color;
        beat.run_count = q_job.count;
        beat.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = (step_r == STEP_RUN) ? STEP_COL_CMD : step_r + 4'd1;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_COL_CMD;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= beat;
    end
  end

endmodule

`default_nettype wire
